FILE: rtl/core/gsm_pkg.sv
// ----------------------------------------------------------------------------
// gsm_pkg
// shared types and constants of the greedy score matching block
// ----------------------------------------------------------------------------
package gsm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int THR_W      = 32;
    localparam int COUNT_W    = 5;
    localparam int FIELD_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDMARKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENTS = 2'd2;

    // control from the scan sequencer to the best-pair search
    typedef struct packed {
        logic clear;
        logic sample;
        logic row_free;
        logic col_free;
    } t_scan_ctl;

endpackage

FILE: rtl/core/gsm_ram.sv
// ----------------------------------------------------------------------------
// gsm_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module gsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gsm_search.sv
// ----------------------------------------------------------------------------
// gsm_search
// keeps the best free pair above threshold seen during one scan of the store
// ----------------------------------------------------------------------------
module gsm_search
    import gsm_pkg::*;
#(
    parameter int SCORE_WIDTH = 32,
    parameter int RW = 4,
    parameter int CW = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_scan_ctl              i_ctl,
    input  logic [SCORE_WIDTH-1:0] i_score,
    input  logic [THR_W-1:0]       i_threshold,
    input  logic [RW-1:0]          i_row,
    input  logic [CW-1:0]          i_col,
    output logic                   o_found,
    output logic [RW-1:0]          o_best_row,
    output logic [CW-1:0]          o_best_col
);

    localparam int CMPW = (SCORE_WIDTH > THR_W) ? SCORE_WIDTH : THR_W;

    logic                   r_found;
    logic [SCORE_WIDTH-1:0] r_best;
    logic [RW-1:0]          r_best_row;
    logic [CW-1:0]          r_best_col;
    logic                   above_thr;
    logic                   beats_best;
    logic                   take;

    assign above_thr  = CMPW'(i_score) > CMPW'(i_threshold);
    assign beats_best = !r_found || (i_score > r_best);
    // strict compare in row-major order keeps the lower index on ties
    assign take = i_ctl.sample && i_ctl.row_free && i_ctl.col_free && above_thr && beats_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best     <= i_score;
            r_best_row <= i_row;
            r_best_col <= i_col;
        end
    end

    assign o_found    = r_found;
    assign o_best_row = r_best_row;
    assign o_best_col = r_best_col;

endmodule

FILE: rtl/core/greedy_score_matching.sv
// ----------------------------------------------------------------------------
// greedy_score_matching
// greedy landmark to measurement assignment over a loaded score matrix
// ----------------------------------------------------------------------------
// The slave stream takes one score per item, row-major, rows*cols items per
// matrix (rows, cols from the landmark and measurement count registers, a
// count of zero used as one and a count above the maximum used as the
// maximum). Scores load at one item per cycle into the score memory.
// After the last score the block stops taking items and runs rounds; each
// round reads the whole matrix through the score memory read port and
// claims the best free pair above the threshold. Rounds end when every
// landmark is matched or no pair is left, so at most rows rounds. Then one
// result per landmark goes out on the master stream; tlast marks the last.
// A stalled receiver holds the pending result and halts the result
// sequencer; loading of the next matrix starts once the last result sits in
// the output register. The configuration channel is always ready; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reset clears the match count, the marks and the load
// position; the threshold resets to zero and both counts to 16.
// ----------------------------------------------------------------------------
module greedy_score_matching
    import gsm_pkg::*;
#(
    parameter int MAX_LANDMARKS    = 16,
    parameter int MAX_MEASUREMENTS = 16,
    parameter int SCORE_WIDTH      = 32,
    localparam int TDW = ((SCORE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // score items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDW-1:0]        s_axis_tdata,   // score
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // landmark_index, measurement_index
    output logic                  m_axis_tuser,   // matched
    output logic                  m_axis_tlast    // last_result
);

    localparam int DEPTH = MAX_LANDMARKS * MAX_MEASUREMENTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TNW   = $clog2(DEPTH + 1);
    localparam int RW    = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CW    = (MAX_MEASUREMENTS > 1) ? $clog2(MAX_MEASUREMENTS) : 1;
    localparam int RNW   = $clog2(MAX_LANDMARKS + 1);
    localparam int CNW   = $clog2(MAX_MEASUREMENTS + 1);

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_FINISH  = 3'd2;
    localparam logic [2:0] S_COMMIT  = 3'd3;
    localparam logic [2:0] S_EMIT_RD = 3'd4;
    localparam logic [2:0] S_EMIT_WR = 3'd5;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [THR_W-1:0]         r_thr;
    logic [COUNT_W-1:0]       r_lm_cnt;
    logic [COUNT_W-1:0]       r_ms_cnt;
    logic [TNW-1:0]           r_load;
    logic [AW-1:0]            r_addr;
    logic [RW-1:0]            r_row;
    logic [CW-1:0]            r_col;
    logic                     r_pv;
    logic [RW-1:0]            r_prow;
    logic [CW-1:0]            r_pcol;
    logic [MAX_LANDMARKS-1:0]    r_lm_taken;
    logic [MAX_MEASUREMENTS-1:0] r_ms_taken;
    logic [RNW-1:0]           r_matched;
    logic [RW-1:0]            r_emit;
    logic                     r_out_valid;
    logic [FIELD_IDX_W-1:0]   r_out_lm;
    logic [FIELD_IDX_W-1:0]   r_out_ms;
    logic                     r_out_match;
    logic                     r_out_last;

    logic [RNW-1:0]           rows;
    logic [CNW-1:0]           cols;
    logic [TNW-1:0]           total;
    logic [TNW-1:0]           load_next;
    logic                     in_acc;
    logic                     out_acc;
    logic                     load_done;
    logic                     scan_last;
    logic                     col_last;
    logic                     emit_last;
    logic                     out_free;
    logic                     commit_done;
    logic [SCORE_WIDTH-1:0]   score_rd;
    logic [CW-1:0]            match_rd;
    t_scan_ctl                scan_ctl;
    logic                     found;
    logic [RW-1:0]            best_row;
    logic [CW-1:0]            best_col;

    // clamped counts
    always_comb begin
        if (r_lm_cnt == '0) begin
            rows = RNW'(1);
        end else if (r_lm_cnt > MAX_LANDMARKS) begin
            rows = RNW'(MAX_LANDMARKS);
        end else begin
            rows = RNW'(r_lm_cnt);
        end
        if (r_ms_cnt == '0) begin
            cols = CNW'(1);
        end else if (r_ms_cnt > MAX_MEASUREMENTS) begin
            cols = CNW'(MAX_MEASUREMENTS);
        end else begin
            cols = CNW'(r_ms_cnt);
        end
    end

    assign total       = TNW'(rows) * TNW'(cols);
    assign load_next   = TNW'(r_load + 1'b1);
    assign in_acc      = s_axis_tvalid && (r_state == S_LOAD);
    assign out_acc     = r_out_valid && m_axis_tready;
    assign load_done   = in_acc && (load_next >= total);
    assign scan_last   = (TNW'(r_addr) + TNW'(1)) == total;
    assign col_last    = (CNW'(r_col) + CNW'(1)) == cols;
    assign emit_last   = (RNW'(r_emit) + RNW'(1)) == rows;
    assign out_free    = !r_out_valid || out_acc;
    assign commit_done = !found || ((r_matched + RNW'(1)) == rows);

    assign scan_ctl.clear    = load_done || (r_state == S_COMMIT);
    assign scan_ctl.sample   = r_pv;
    assign scan_ctl.row_free = !r_lm_taken[r_prow];
    assign scan_ctl.col_free = !r_ms_taken[r_pcol];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (load_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = commit_done ? S_EMIT_RD : S_SCAN;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (out_free) begin
                    n_state = emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_thr       <= '0;
            r_lm_cnt    <= COUNT_W'(16);
            r_ms_cnt    <= COUNT_W'(16);
            r_load      <= '0;
            r_pv        <= 1'b0;
            r_lm_taken  <= '0;
            r_ms_taken  <= '0;
            r_matched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:    r_thr    <= i_cfg_data[THR_W-1:0];
                    CFG_LANDMARKS:    r_lm_cnt <= i_cfg_data[COUNT_W-1:0];
                    CFG_MEASUREMENTS: r_ms_cnt <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_load <= load_done ? '0 : load_next;
            end
            r_pv <= (r_state == S_SCAN);
            if (load_done) begin
                r_lm_taken <= '0;
                r_ms_taken <= '0;
                r_matched  <= '0;
            end else if (r_state == S_COMMIT && found) begin
                r_lm_taken[best_row] <= 1'b1;
                r_ms_taken[best_col] <= 1'b1;
                r_matched            <= RNW'(r_matched + 1'b1);
            end
            if (r_state == S_EMIT_WR && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan and result positions, output payload
    always_ff @(posedge i_clk) begin
        if (load_done || (r_state == S_COMMIT)) begin
            r_addr <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (r_state == S_SCAN) begin
            r_addr <= AW'(r_addr + 1'b1);
            if (col_last) begin
                r_col <= '0;
                r_row <= RW'(r_row + 1'b1);
            end else begin
                r_col <= CW'(r_col + 1'b1);
            end
        end
        r_prow <= r_row;
        r_pcol <= r_col;
        if (r_state == S_COMMIT) begin
            r_emit <= '0;
        end else if (r_state == S_EMIT_WR && out_free) begin
            r_emit <= RW'(r_emit + 1'b1);
        end
        if (r_state == S_EMIT_WR && out_free) begin
            r_out_lm    <= FIELD_IDX_W'(r_emit);
            r_out_ms    <= r_lm_taken[r_emit] ? FIELD_IDX_W'(match_rd) : '0;
            r_out_match <= r_lm_taken[r_emit];
            r_out_last  <= emit_last;
        end
    end

    gsm_ram #(
        .WIDTH (SCORE_WIDTH),
        .DEPTH (DEPTH)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (AW'(r_load)),
        .i_wdata (s_axis_tdata[SCORE_WIDTH-1:0]),
        .i_raddr (r_addr),
        .o_rdata (score_rd)
    );

    // match index per landmark, valid when the landmark is taken
    gsm_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LANDMARKS)
    ) u_match_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_COMMIT) && found),
        .i_waddr (best_row),
        .i_wdata (best_col),
        .i_raddr (r_emit),
        .o_rdata (match_rd)
    );

    gsm_search #(
        .SCORE_WIDTH (SCORE_WIDTH),
        .RW          (RW),
        .CW          (CW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_score     (score_rd),
        .i_threshold (r_thr),
        .i_row       (r_prow),
        .i_col       (r_pcol),
        .o_found     (found),
        .o_best_row  (best_row),
        .o_best_col  (best_col)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ms, r_out_lm};
    assign m_axis_tuser  = r_out_match;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_taken_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_lm_taken) == r_matched)
        else $error("landmark marks disagree with match count");

    a_taken_pairs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_lm_taken) == $countones(r_ms_taken))
        else $error("landmark and measurement marks out of step");

    a_commit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && found) |-> (!r_lm_taken[best_row] && !r_ms_taken[best_col]))
        else $error("committed pair already taken");

    a_match_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_matched <= rows))
        else $error("more matches than landmarks");
`endif

endmodule

FILE: test/tb_greedy_score_matching.sv
// ----------------------------------------------------------------------------
// tb_greedy_score_matching
// self-checking testbench for the greedy score matching block
// ----------------------------------------------------------------------------
// Score matrices go in on the slave stream and the configuration registers
// are set between matrices. A behavioural model in the testbench holds its
// own copy of the score store and the registers. When a matrix completes, it
// runs the greedy assignment and queues one expected result per landmark.
// Each result on the master stream is checked field by field against the
// oldest queued one. The directed tests cover the reset values, count
// clamping, threshold edges, tie breaking and counts changed mid-load.
// Random phases follow, then a long receiver hold-off and a final stretch
// with no idling on either side.
// ----------------------------------------------------------------------------
module tb_greedy_score_matching
    import gsm_pkg::*;
;

    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 100;
    localparam int RANDOM_ITEMS  = 60;
    localparam int MAX_DIM       = 16;

    typedef struct packed {
        logic [FIELD_IDX_W-1:0] landmark;
        logic [FIELD_IDX_W-1:0] measurement;
        logic                   matched;
        logic                   last;
    } t_match_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // score
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // landmark_index, measurement_index
    logic                  m_axis_tuser;   // matched
    logic                  m_axis_tlast;   // last_result

    // model state
    logic [THR_W-1:0]   threshold_reg;
    logic [COUNT_W-1:0] landmark_reg;
    logic [COUNT_W-1:0] measurement_reg;
    logic [31:0]        score_mem [MAX_DIM*MAX_DIM];
    int                 load_pos;
    t_match_result      pending_matches [$];

    t_match_result      want;
    int                 mismatch_count;
    int                 items_sent;
    int                 stall_cycles;
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    int                 rx_hold_req;
    int                 rx_hold_left;
    int                 rx_burst_left;

    greedy_score_matching u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_count(input logic [COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < 100)
            $display("mismatch: %s got %0d expected %0d", what, got, exp_val);
        mismatch_count++;
    endtask

    // greedy assignment over the stored matrix, one result per landmark
    task automatic run_greedy_match(input int rows, input int cols);
        logic          row_used  [MAX_DIM];
        logic          col_used  [MAX_DIM];
        logic          has_match [MAX_DIM];
        int            match_col [MAX_DIM];
        int            claimed;
        logic          found;
        logic          done;
        int            best_r;
        int            best_c;
        logic [31:0]   best;
        logic [31:0]   s;
        t_match_result res;
        for (int i = 0; i < MAX_DIM; i++) begin
            row_used[i]  = 1'b0;
            col_used[i]  = 1'b0;
            has_match[i] = 1'b0;
            match_col[i] = 0;
        end
        claimed = 0;
        done    = 1'b0;
        while (!done && claimed < rows) begin
            found  = 1'b0;
            best   = '0;
            best_r = 0;
            best_c = 0;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    s = score_mem[r*cols + c];
                    // strict compare keeps the earlier pair on equal scores
                    if (!row_used[r] && !col_used[c] && s > threshold_reg
                            && (!found || s > best)) begin
                        found  = 1'b1;
                        best   = s;
                        best_r = r;
                        best_c = c;
                    end
                end
            end
            if (!found) begin
                done = 1'b1;
            end else begin
                row_used[best_r]  = 1'b1;
                col_used[best_c]  = 1'b1;
                has_match[best_r] = 1'b1;
                match_col[best_r] = best_c;
                claimed++;
            end
        end
        for (int r = 0; r < rows; r++) begin
            res.landmark    = 4'(r);
            res.measurement = has_match[r] ? 4'(match_col[r]) : 4'd0;
            res.matched     = has_match[r];
            res.last        = (r + 1 == rows);
            pending_matches.push_back(res);
        end
    endtask

    task automatic absorb_score(input logic [31:0] s);
        int rows;
        int cols;
        rows = clamp_count(landmark_reg);
        cols = clamp_count(measurement_reg);
        if (load_pos < MAX_DIM*MAX_DIM)
            score_mem[load_pos] = s;
        load_pos++;
        if (load_pos >= rows*cols) begin
            load_pos = 0;
            run_greedy_match(rows, cols);
        end
    endtask

    task automatic send_score(input logic [31:0] s);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        absorb_score(s);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD:    threshold_reg   = data[THR_W-1:0];
            CFG_LANDMARKS:    landmark_reg    = data[COUNT_W-1:0];
            CFG_MEASUREMENTS: measurement_reg = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_counts(input int rows, input int cols);
        cfg_write(CFG_LANDMARKS, CFG_DATA_W'(rows));
        cfg_write(CFG_MEASUREMENTS, CFG_DATA_W'(cols));
    endtask

    // stop offering items, wait for every queued result, let the block settle
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_score();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return threshold_reg;
            3:       return threshold_reg + 32'd1;
            4, 5:    return threshold_reg + 32'($urandom_range(1, 4));
            6:       return 32'd0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 32'h0004_0000));
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(17, 31);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // keep sending until the model sees the matrix complete
    task automatic finish_matrix();
        send_score(pick_score());
        while (load_pos != 0) send_score(pick_score());
    endtask

    task automatic test_reset_defaults();
        // 16 by 16 and threshold zero straight out of reset
        repeat (MAX_DIM*MAX_DIM) send_score(pick_score());
        quiesce();
    endtask

    task automatic test_single_cell();
        cfg_write(CFG_THRESHOLD, 32'd0);
        set_counts(0, 0);
        send_score(32'hFFFF_FFFF);
        send_score(32'd0);
        quiesce();
        cfg_write(CFG_THRESHOLD, 32'hFFFF_FFFF);
        send_score(32'hFFFF_FFFF);
        quiesce();
        cfg_write(CFG_THRESHOLD, 32'h0001_0000);
        send_score(32'h0001_0000);
        send_score(32'h0001_0001);
        quiesce();
    endtask

    task automatic test_tie_break();
        cfg_write(CFG_THRESHOLD, 32'd0);
        set_counts(2, 2);
        repeat (4) send_score(32'd7);
        quiesce();
        set_counts(2, 3);
        send_score(32'd5);
        send_score(32'd9);
        send_score(32'd9);
        send_score(32'd9);
        send_score(32'd3);
        send_score(32'd1);
        quiesce();
    endtask

    task automatic test_count_change_mid_load();
        cfg_write(CFG_THRESHOLD, 32'd4);
        set_counts(3, 3);
        repeat (5) send_score(pick_score());
        quiesce();
        // load position already past the new size
        set_counts(2, 2);
        send_score(pick_score());
        quiesce();
        set_counts(1, 2);
        send_score(pick_score());
        quiesce();
        set_counts(2, 2);
        repeat (3) send_score(pick_score());
        quiesce();
    endtask

    task automatic random_phase();
        int rows;
        int cols;
        int total;
        int nmat;
        quiesce();
        cfg_write(CFG_THRESHOLD, pick_threshold());
        rows = pick_count();
        cols = pick_count();
        if (clamp_count(5'(rows)) * clamp_count(5'(cols)) > 36)
            cols = $urandom_range(1, 2);
        set_counts(rows, cols);
        nmat = $urandom_range(1, 4);
        repeat (nmat) begin
            total = clamp_count(landmark_reg) * clamp_count(measurement_reg);
            if (total > 1 && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, total - 1)) send_score(pick_score());
                quiesce();
                set_counts($urandom_range(0, 5), $urandom_range(1, 5));
            end
            finish_matrix();
        end
    endtask

    task automatic test_random_mix();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) random_phase();
        quiesce();
    endtask

    task automatic test_output_backpressure();
        cfg_write(CFG_THRESHOLD, pick_threshold());
        set_counts(4, 4);
        rx_hold_req = 300;
        repeat (3) finish_matrix();
        quiesce();
    endtask

    task automatic test_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (4) begin
            quiesce();
            cfg_write(CFG_THRESHOLD, pick_threshold());
            set_counts($urandom_range(1, 5), $urandom_range(1, 5));
            repeat ($urandom_range(1, 3)) finish_matrix();
        end
        quiesce();
    endtask

    // receiver with random idle bursts and a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        rx_hold_left  = 0;
        rx_burst_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready = 1'b0;
            end else if (rx_burst_left > 0) begin
                rx_burst_left--;
                m_axis_tready = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                rx_burst_left = $urandom_range(1, 4) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_matches.size() == 0) begin
                report_mismatch("unexpected result, landmark", int'(m_axis_tdata[3:0]), -1);
            end else begin
                want = pending_matches.pop_front();
                if (m_axis_tdata[3:0] !== want.landmark)
                    report_mismatch("landmark_index", int'(m_axis_tdata[3:0]),
                                    int'(want.landmark));
                if (m_axis_tdata[7:4] !== want.measurement)
                    report_mismatch("measurement_index", int'(m_axis_tdata[7:4]),
                                    int'(want.measurement));
                if (m_axis_tuser !== want.matched)
                    report_mismatch("matched", int'(m_axis_tuser), int'(want.matched));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_result", int'(m_axis_tlast), int'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_THRESHOLD;
        i_cfg_data      = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        threshold_reg   = '0;
        landmark_reg    = COUNT_W'(MAX_DIM);
        measurement_reg = COUNT_W'(MAX_DIM);
        load_pos        = 0;
        mismatch_count  = 0;
        items_sent      = 0;
        stall_cycles    = 0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        rx_hold_req     = 0;
        for (int i = 0; i < MAX_DIM*MAX_DIM; i++)
            score_mem[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_single_cell();
        test_tie_break();
        test_count_change_mid_load();
        test_random_mix();
        test_output_backpressure();
        test_no_idle();

        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_matches.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
